// ----- sv/rmd_pkg.sv -----
// ----------------------------------------------------------------------------
// rmd_pkg
// Types and constants shared by the median depth block.
// ----------------------------------------------------------------------------
package rmd_pkg;

   localparam int FW_W    = 10;   // frame_width register
   localparam int FH_W    = 9;    // frame_height register
   localparam int CNT_W   = 19;   // pixel counts inside one box
   localparam int BINS    = 256;
   localparam int ENTRY_W = 17;   // bit 16 valid, bits 15..0 depth
   localparam int Q_DEPTH = 2;

   localparam logic FW_RESET_ADDR = 1'b0;
   localparam logic FH_RESET_ADDR = 1'b1;
   localparam logic [FW_W-1:0] FW_RESET = 10'd640;
   localparam logic [FH_W-1:0] FH_RESET = 9'd480;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic               action;
      logic [18:0]        pixel_index;
      logic [15:0]        depth_mm;
      logic               depth_valid;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [14:0]        size_x;
      logic [14:0]        size_y;
      logic [15:0]        class_tag;
   } req_type;

   typedef struct packed {
      logic [15:0] result_class;
      logic [15:0] distance_mm;
   } rsp_type;

   // One classified item as it waits between front and back.
   typedef struct packed {
      logic            is_query;
      logic [18:0]     pixel_index;
      logic [16:0]     entry;
      logic [FW_W-1:0] x0;
      logic [FW_W-1:0] x1;
      logic [FH_W-1:0] y0;
      logic [FH_W-1:0] y1;
      logic [15:0]     class_tag;
   } cmd_type;

endpackage

// ----- sv/rmd_ram.sv -----
// ----------------------------------------------------------------------------
// rmd_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- sv/rmd_front.sv -----
// ----------------------------------------------------------------------------
// rmd_front
// Accepts items, turns query boxes into clipped pixel rectangles and
// queues the work for the back end. Empty boxes are dropped here.
// ----------------------------------------------------------------------------
module rmd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rmd_pkg::req_type          req_data,
   input  logic [rmd_pkg::FW_W-1:0]  frame_width,
   input  logic [rmd_pkg::FH_W-1:0]  frame_height,
   output logic                      cmd_valid,
   output rmd_pkg::cmd_type          cmd,
   input  logic                      cmd_pop
);
   import rmd_pkg::*;

   cmd_type     q_ff [Q_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   logic signed [12:0] x0_s, x1_s, y0_s, y1_s;
   logic               empty, push;
   cmd_type            new_cmd;

   // Low edge clipped at zero, high edge truncated toward zero and clipped
   // to the last pixel of the frame.
   function automatic logic signed [12:0] low_edge(input logic signed [15:0] c,
                                                   input logic [14:0] s);
      logic signed [17:0] t;
      t = 18'(signed'({c, 1'b0})) - signed'({3'b0, s});
      return t[17] ? 13'sd0 : signed'({1'b0, t[16:5]});
   endfunction

   function automatic logic signed [12:0] high_edge(input logic signed [15:0] c,
                                                    input logic [14:0] s,
                                                    input logic [9:0] lim);
      logic signed [17:0] t;
      logic signed [17:0] adj;
      logic signed [12:0] e;
      logic signed [12:0] l;
      t   = 18'(signed'({c, 1'b0})) + signed'({3'b0, s});
      adj = t + (t[17] ? 18'sd31 : 18'sd0);
      e   = adj[17:5];
      l   = signed'({3'b0, lim}) - 13'sd1;
      return (e < l) ? e : l;
   endfunction

   always_comb begin
      x0_s  = low_edge(req_data.center_x, req_data.size_x);
      x1_s  = high_edge(req_data.center_x, req_data.size_x, frame_width);
      y0_s  = low_edge(req_data.center_y, req_data.size_y);
      y1_s  = high_edge(req_data.center_y, req_data.size_y, {1'b0, frame_height});
      empty = (x0_s > x1_s) || (y0_s > y1_s);

      new_cmd.is_query    = (req_data.action == ACT_QUERY);
      new_cmd.pixel_index = req_data.pixel_index;
      new_cmd.entry       = {req_data.depth_valid, req_data.depth_mm};
      new_cmd.x0          = x0_s[FW_W-1:0];
      new_cmd.x1          = x1_s[FW_W-1:0];
      new_cmd.y0          = y0_s[FH_W-1:0];
      new_cmd.y1          = y1_s[FH_W-1:0];
      new_cmd.class_tag   = req_data.class_tag;
   end

   assign req_stall = (count_ff == 2'(Q_DEPTH));
   assign push = req_valid && !req_stall && (!new_cmd.is_query || !empty);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

// ----- sv/rmd_back.sv -----
// ----------------------------------------------------------------------------
// rmd_back
// Executes queued work: writes loaded pixels to the frame store and, for a
// query, builds a histogram of high depth bytes, finds the median bin, then
// repeats with the low bytes of that bin.
// ----------------------------------------------------------------------------
module rmd_back #(
   parameter int MAX_WIDTH  = 640,
   parameter int MAX_HEIGHT = 480
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [rmd_pkg::FW_W-1:0] frame_width,
   input  logic                     cmd_valid,
   input  rmd_pkg::cmd_type         cmd,
   output logic                     cmd_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rmd_pkg::rsp_type         rsp_data
);
   import rmd_pkg::*;

   localparam int STORE  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(STORE);
   localparam int WIDE_W = (ADDR_W > 20) ? ADDR_W : 20;
   localparam logic [31:0] STORE_SIZE = 32'(STORE);

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_PIX_RD, S_PIX_CHK, S_HIST_UPD, S_NEXT,
      S_PICK_RD, S_PICK_CHK, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [FW_W-1:0]  x0_ff, x0_in, x1_ff, x1_in, x_ff, x_in;
   logic [FH_W-1:0]  y0_ff, y0_in, y1_ff, y1_in, y_ff, y_in;
   logic [15:0]      class_ff, class_in;
   logic [CNT_W-1:0] row_ff, row_in, n_ff, n_in, rank_ff, rank_in;
   logic             pass_ff, pass_in;
   logic [7:0]       bin_ff, bin_in, hi_ff, hi_in;
   logic [8:0]       cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [WIDE_W-1:0]  idx_wide, ld_wide;
   logic               idx_ok, ld_ok;
   logic               fr_we;
   logic [ADDR_W-1:0]  fr_waddr, fr_raddr;
   logic [ENTRY_W-1:0] fr_rdata;
   logic               h_we;
   logic [7:0]         h_waddr, h_raddr;
   logic [CNT_W-1:0]   h_wdata, h_rdata;
   logic               out_free;

   rmd_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE)) u_frame (
      .clock(clock), .we(fr_we), .waddr(fr_waddr), .wdata(cmd.entry),
      .raddr(fr_raddr), .rdata(fr_rdata)
   );

   rmd_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_hist (
      .clock(clock), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
      .raddr(h_raddr), .rdata(h_rdata)
   );

   assign idx_wide = WIDE_W'(row_ff) + WIDE_W'(x_ff);
   assign idx_ok   = 32'(idx_wide) < STORE_SIZE;
   assign ld_wide  = WIDE_W'(cmd.pixel_index);
   assign ld_ok    = 32'(ld_wide) < STORE_SIZE;
   assign fr_raddr = idx_wide[ADDR_W-1:0];
   assign fr_waddr = ld_wide[ADDR_W-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      x0_in = x0_ff; x1_in = x1_ff; x_in = x_ff;
      y0_in = y0_ff; y1_in = y1_ff; y_in = y_ff;
      class_in     = class_ff;
      row_in       = row_ff;
      n_in         = n_ff;
      rank_in      = rank_ff;
      pass_in      = pass_ff;
      bin_in       = bin_ff;
      hi_in        = hi_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd_pop      = 1'b0;
      fr_we        = 1'b0;
      h_we         = 1'b0;
      h_waddr      = bin_ff;
      h_wdata      = h_rdata + 1'b1;
      h_raddr      = bin_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (!cmd.is_query) begin
                  fr_we = ld_ok;
               end else begin
                  x0_in    = cmd.x0;
                  x1_in    = cmd.x1;
                  y0_in    = cmd.y0;
                  y1_in    = cmd.y1;
                  class_in = cmd.class_tag;
                  pass_in  = 1'b0;
                  cnt_in   = 9'd0;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            h_we    = 1'b1;
            h_waddr = cnt_ff[7:0];
            h_wdata = '0;
            cnt_in  = cnt_ff + 9'd1;
            if (cnt_ff[7:0] == 8'(BINS - 1)) begin
               x_in     = x0_ff;
               y_in     = y0_ff;
               row_in   = CNT_W'(y0_ff) * CNT_W'(frame_width);
               n_in     = '0;
               state_in = S_PIX_RD;
            end
         end
         S_PIX_RD: begin
            state_in = idx_ok ? S_PIX_CHK : S_NEXT;
         end
         S_PIX_CHK: begin
            // Pass one counts high bytes; pass two counts low bytes of the
            // chosen high bin only.
            h_raddr = pass_ff ? fr_rdata[7:0] : fr_rdata[15:8];
            if (fr_rdata[16] && (!pass_ff || fr_rdata[15:8] == hi_ff)) begin
               bin_in   = h_raddr;
               state_in = S_HIST_UPD;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_HIST_UPD: begin
            h_we     = 1'b1;
            n_in     = n_ff + 1'b1;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            state_in = S_PIX_RD;
            if (x_ff == x1_ff) begin
               x_in = x0_ff;
               if (y_ff == y1_ff) begin
                  bin_in = 8'd0;
                  if (!pass_ff) begin
                     rank_in  = n_ff >> 1;
                     state_in = (n_ff == '0) ? S_IDLE : S_PICK_RD;
                  end else begin
                     state_in = S_PICK_RD;
                  end
               end else begin
                  y_in   = y_ff + 1'b1;
                  row_in = row_ff + CNT_W'(frame_width);
               end
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         S_PICK_RD: begin
            state_in = S_PICK_CHK;
         end
         S_PICK_CHK: begin
            if (rank_ff < h_rdata || bin_ff == 8'(BINS - 1)) begin
               if (!pass_ff) begin
                  hi_in    = bin_ff;
                  pass_in  = 1'b1;
                  cnt_in   = 9'd0;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               rank_in  = rank_ff - h_rdata;
               bin_in   = bin_ff + 1'b1;
               state_in = S_PICK_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in.result_class = class_ff;
               rsp_in.distance_mm  = {hi_ff, bin_ff};
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x0_ff    <= x0_in;
      x1_ff    <= x1_in;
      x_ff     <= x_in;
      y0_ff    <= y0_in;
      y1_ff    <= y1_in;
      y_ff     <= y_in;
      class_ff <= class_in;
      row_ff   <= row_in;
      n_ff     <= n_in;
      rank_ff  <= rank_in;
      pass_ff  <= pass_in;
      bin_ff   <= bin_in;
      hi_ff    <= hi_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ----- sv/roi_median_depth_core.sv -----
// ----------------------------------------------------------------------------
// roi_median_depth_core
// Median valid depth inside a detection box over a stored depth frame.
// ----------------------------------------------------------------------------
// A load item writes one pixel into the frame store, so pixels can stream in
// at one per cycle while no query is being worked on. A query walks its box
// through the single read port of the frame store twice. Each pass clears the
// 256-bin histogram memory, reads each pixel of the box, skips pixels that
// fall beyond the store, counts the valid pixels that the pass selects, and
// then examines histogram bins up to the chosen one. The item is taken from
// the queue before the first pass and the result is loaded after the second;
// a box with no valid depth ends after the first walk with no result.
// Two queued items decouple intake from execution; a result waits in an
// output register while the next items are accepted.
module roi_median_depth_core #(
   parameter int MAX_WIDTH  = 640,
   parameter int MAX_HEIGHT = 480
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rmd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rmd_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import rmd_pkg::*;

   logic [FW_W-1:0] fw_ff;
   logic [FH_W-1:0] fh_ff;
   logic            cfg_wr;
   logic            cmd_valid, cmd_pop;
   cmd_type         cmd;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == FH_RESET_ADDR) ? 32'(fh_ff) : 32'(fw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FW_RESET;
         fh_ff <= FH_RESET;
      end else if (cfg_wr) begin
         if (paddr[2] == FW_RESET_ADDR) begin
            fw_ff <= pwdata[FW_W-1:0];
         end else begin
            fh_ff <= pwdata[FH_W-1:0];
         end
      end
   end

   rmd_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .frame_width(fw_ff), .frame_height(fh_ff),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
   );

   rmd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock(clock), .reset(reset), .frame_width(fw_ff),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );
endmodule
